>>> src/assert_macros.svh
// Assertion macros for the RTL of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

>>> src/utf8d_pkg.sv
// Types and constants shared by the UTF-8 decoder unit and its testbench.
`default_nettype none

package utf8d_pkg;

    // Lookup table geometry.
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 16;
    localparam int VAL_W       = 8;
    localparam int ENTRY_W     = KEY_W + VAL_W;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register reset values.
    localparam logic [7:0]  RST_FIRST_ACCENTED = 8'd128;
    localparam logic [15:0] RST_FIRST_MAPPED   = 16'd128;
    localparam logic [7:0]  RST_UNDEFINED_BYTE = 8'd63;

    // Register indexes (word address).
    typedef enum logic [2:0] {
        REG_PASSTHROUGH    = 3'd0,
        REG_FIRST_ACCENTED = 3'd1,
        REG_FIRST_MAPPED   = 3'd2,
        REG_UNDEFINED_BYTE = 3'd3,
        REG_TABLE_SIZE     = 3'd4
    } cfg_reg_t;

    // Input operation codes.
    typedef enum logic {
        OP_DECODE = 1'b0,
        OP_WRITE  = 1'b1
    } op_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    // Input transaction payload.
    typedef struct packed {
        logic        operation;
        logic [7:0]  data_byte;
        logic [7:0]  entry_index;
        logic [15:0] entry_code;
        logic [7:0]  entry_byte;
    } item_t;

    // Output transaction payload.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       error;
        logic       substituted;
    } result_t;

endpackage

`default_nettype wire

>>> src/utf8d_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module utf8d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/utf8_to_single_byte_decoder_unit.sv
// UTF-8 to single-byte charset decoder: top level with table search sequencer.
//
// Input transactions carry either a UTF-8 data byte to decode or a write of one
// lookup table entry (key, value). A transaction is taken when item_valid is high
// and item_stall is low; item_stall is high whenever the sequencer is busy.
// Each decoded character gives one result transaction on the result channel;
// lead and middle bytes of a sequence and table writes give none.
// A table write leaves the sequencer idle. A byte that needs no table lookup
// goes through the pending result register and ST_DONE into the output register
// and onto the result channel; the next item is taken once the sequencer is back
// in ST_IDLE. A code point at or above first_mapped_reg is binary-searched over
// the table RAM; each probe goes through ST_READ (address) and ST_CMP (registered
// read data and compare). The result sits in an output register; a stalled
// result holds its value, and the sequencer waits with the next result until
// that register is free, while a new item may still be taken when the register
// is merely full. Reset clears the decode state and loads the register defaults;
// table contents are undefined until written. Configuration must be written
// over the APB port only while the block is idle; the block itself does not
// enforce this.
`default_nettype none

`include "assert_macros.svh"

module utf8_to_single_byte_decoder_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input channel.
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire utf8d_pkg::item_t                    item,
    // Result channel.
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output utf8d_pkg::result_t                       result,
    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [utf8d_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [utf8d_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [utf8d_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                     pready
);

    import utf8d_pkg::*;

    // Configuration registers.
    logic        passthrough_reg;
    logic [7:0]  first_accented_reg;
    logic [15:0] first_mapped_reg;
    logic [7:0]  undefined_byte_reg;
    logic [8:0]  table_size_reg;

    // Decode and search state.
    state_t           state_reg, state_next;
    logic [15:0]      partial_reg, partial_next;
    logic [1:0]       pending_reg, pending_next;
    logic [15:0]      code_reg, code_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    result_t          res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_data_reg, out_data_next;

    // Decode of the accepted transaction.
    logic             item_accept;
    logic             cfg_write;
    logic             tbl_we;
    logic [IDX_W-1:0] tbl_waddr;
    logic [IDX_W-1:0] tbl_raddr;
    logic [ENTRY_W-1:0] tbl_rdata;
    logic [KEY_W-1:0] probe_key;
    logic [VAL_W-1:0] probe_val;
    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid_calc;
    logic [CNT_W-1:0] size_used;
    logic             out_free;
    logic             dec_result;
    logic             dec_search;
    result_t          dec_res;
    logic [15:0]      dec_code;
    logic [15:0]      cont_sum;
    logic [7:0]       b;

    // Configuration writes and reads.
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            passthrough_reg    <= 1'b0;
            first_accented_reg <= RST_FIRST_ACCENTED;
            first_mapped_reg   <= RST_FIRST_MAPPED;
            undefined_byte_reg <= RST_UNDEFINED_BYTE;
            table_size_reg     <= 9'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(paddr[4:2]))
                REG_PASSTHROUGH:    passthrough_reg    <= pwdata[0];
                REG_FIRST_ACCENTED: first_accented_reg <= pwdata[7:0];
                REG_FIRST_MAPPED:   first_mapped_reg   <= pwdata[15:0];
                REG_UNDEFINED_BYTE: undefined_byte_reg <= pwdata[7:0];
                REG_TABLE_SIZE:     table_size_reg     <= pwdata[8:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_reg_t'(paddr[4:2]))
            REG_PASSTHROUGH:    prdata = APB_DATA_W'(passthrough_reg);
            REG_FIRST_ACCENTED: prdata = APB_DATA_W'(first_accented_reg);
            REG_FIRST_MAPPED:   prdata = APB_DATA_W'(first_mapped_reg);
            REG_UNDEFINED_BYTE: prdata = APB_DATA_W'(undefined_byte_reg);
            REG_TABLE_SIZE:     prdata = APB_DATA_W'(table_size_reg);
            default:            prdata = '0;
        endcase
    end

    // Table RAM: key in the upper bits, charset byte in the lower bits.
    assign tbl_we    = item_accept && (item.operation == OP_WRITE) &&
                       (32'(item.entry_index) < TABLE_DEPTH);
    assign tbl_waddr = IDX_W'(item.entry_index);

    utf8d_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata ({item.entry_code, item.entry_byte}),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    assign probe_key = tbl_rdata[ENTRY_W-1:VAL_W];
    assign probe_val = tbl_rdata[VAL_W-1:0];

    // Midpoint of the live window [lo, hi).
    assign mid_sum   = (CNT_W+1)'(lo_reg) + (CNT_W+1)'(hi_reg) - (CNT_W+1)'(1);
    assign mid_calc  = mid_sum[CNT_W:1];
    assign tbl_raddr = IDX_W'(mid_calc);

    // Number of entries searched, limited to the table depth.
    assign size_used = (32'(table_size_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                           : CNT_W'(table_size_reg);

    assign out_free    = !out_valid_reg || !result_stall;
    assign item_accept = item_valid && !item_stall;

    // Byte decoder: classifies the incoming byte against the partial sequence.
    assign b        = item.data_byte;
    assign cont_sum = (pending_reg == 2'd2) ? (partial_reg + {4'd0, b[5:0], 6'd0})
                                            : (partial_reg + {10'd0, b[5:0]});

    always_comb
    begin
        dec_result   = 1'b0;
        dec_search   = 1'b0;
        dec_res      = '0;
        dec_code     = 16'd0;
        partial_next = partial_reg;
        pending_next = pending_reg;
        if (item_accept && (item.operation == OP_DECODE))
        begin
            priority if (passthrough_reg)
            begin
                partial_next         = 16'd0;
                pending_next         = 2'd0;
                dec_result           = 1'b1;
                dec_res.out_byte     = b;
            end
            else if (pending_reg != 2'd0)
            begin
                if (!b[7])
                begin
                    partial_next  = 16'd0;
                    pending_next  = 2'd0;
                    dec_result    = 1'b1;
                    dec_res.error = 1'b1;
                end
                else if (pending_reg == 2'd2)
                begin
                    partial_next = cont_sum;
                    pending_next = 2'd1;
                end
                else
                begin
                    partial_next = 16'd0;
                    pending_next = 2'd0;
                    dec_code     = cont_sum;
                    dec_search   = 1'b1;
                end
            end
            else if (b < first_accented_reg)
            begin
                dec_result       = 1'b1;
                dec_res.out_byte = b;
            end
            else if (b < 8'h7F)
            begin
                dec_code   = {8'd0, b};
                dec_search = 1'b1;
            end
            else if (b[7:5] == 3'b110)
            begin
                partial_next = {5'd0, b[4:0], 6'd0};
                pending_next = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                partial_next = {b[3:0], 12'd0};
                pending_next = 2'd2;
            end
            else
            begin
                partial_next  = 16'd0;
                pending_next  = 2'd0;
                dec_result    = 1'b1;
                dec_res.error = 1'b1;
            end
            // A finished code point below the mapped range goes out directly.
            if (dec_search && (dec_code < first_mapped_reg))
            begin
                dec_search       = 1'b0;
                dec_result       = 1'b1;
                dec_res.out_byte = dec_code[7:0];
            end
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (dec_search)
                begin
                    state_next = ST_READ;
                end
                else if (dec_result)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = (lo_reg < hi_reg) ? ST_CMP : ST_DONE;
            end
            ST_CMP:
            begin
                state_next = (probe_key == code_reg) ? ST_DONE : ST_READ;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: item_stall = 1'b0;
            default: item_stall = 1'b1;
        endcase
    end

    // Search window, pending result and output register updates.
    always_comb
    begin
        code_next      = code_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                code_next = dec_code;
                lo_next   = '0;
                hi_next   = size_used;
                res_next  = dec_res;
            end
            ST_READ:
            begin
                mid_next = mid_calc;
                // An empty window is a miss.
                res_next.out_byte    = undefined_byte_reg;
                res_next.error       = 1'b0;
                res_next.substituted = 1'b1;
            end
            ST_CMP:
            begin
                priority if (probe_key == code_reg)
                begin
                    res_next.out_byte    = probe_val;
                    res_next.error       = 1'b0;
                    res_next.substituted = 1'b0;
                end
                else if (code_reg > probe_key)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            partial_reg   <= 16'd0;
            pending_reg   <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            partial_reg   <= partial_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // A probe only compares an entry that lies inside the live window.
    `ASSERT_IMPLIES(a_probe_in_window, clk, rst_n, state_reg == ST_CMP, mid_reg < hi_reg)
    // An error result never carries a byte or a substitution flag.
    `ASSERT_IMPLIES(a_error_clean, clk, rst_n, result_valid && result.error, result.out_byte == 8'd0 && !result.substituted)
    // A finished result moves to a free output register in the next cycle.
    `ASSERT_NEXT(a_done_delivers, clk, rst_n, state_reg == ST_DONE && out_free, result_valid && state_reg == ST_IDLE)

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the UTF-8 to single-byte charset decoder unit.
`timescale 1ns / 100ps

module tb;
    import utf8d_pkg::*;

    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int IDLE_PERCENT  = 37;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 150;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    item_t                 item         = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow copy of the decoder configuration and state.
    logic        pass_mode;
    logic [7:0]  first_accented;
    logic [15:0] first_mapped;
    logic [7:0]  undefined_byte;
    logic [8:0]  table_size;
    logic [15:0] partial_code;
    logic [1:0]  bytes_pending;
    logic [15:0] key_table [TABLE_DEPTH];
    logic [7:0]  byte_table [TABLE_DEPTH];

    // Decoded characters still owed by the block, oldest first.
    result_t     pending_chars [$];
    result_t     want;

    bit steady;
    int mismatches;
    int items_sent;
    int results_seen;
    int hits;
    int substitutions;
    int seq_errors;
    int settings_applied;
    int quiet_cycles;

    utf8_to_single_byte_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
    endfunction

    // Binary search of the sorted key table for a finished code point.
    function automatic result_t lookup_code(logic [15:0] code);
        result_t r;
        int      lo;
        int      hi;
        int      mid;
        int      span;
        r = '0;
        if (code < first_mapped)
        begin
            r.out_byte = code[7:0];
            return r;
        end
        span = (table_size > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_size);
        lo = 0;
        hi = span - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (key_table[mid] == code)
            begin
                r.out_byte = byte_table[mid];
                hits++;
                return r;
            end
            if (code > key_table[mid])
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        r.out_byte    = undefined_byte;
        r.substituted = 1'b1;
        substitutions++;
        return r;
    endfunction

    // Advances the shadow decoder by one accepted transaction.
    function automatic bit predict_item(item_t it, output result_t r);
        logic [7:0] b;
        logic [15:0] code;
        b = it.data_byte;
        r = '0;
        if (it.operation == OP_WRITE)
        begin
            key_table[it.entry_index]  = it.entry_code;
            byte_table[it.entry_index] = it.entry_byte;
            return 1'b0;
        end
        if (pass_mode)
        begin
            partial_code  = '0;
            bytes_pending = '0;
            r.out_byte    = b;
            return 1'b1;
        end
        // Continuation bytes are taken whatever the pass-through threshold is.
        if (bytes_pending != 2'd0)
        begin
            if (b < 8'd128)
            begin
                partial_code  = '0;
                bytes_pending = '0;
                r.error       = 1'b1;
                seq_errors++;
                return 1'b1;
            end
            if (bytes_pending == 2'd2)
                partial_code = partial_code + {4'b0, b[5:0], 6'b0};
            else
                partial_code = partial_code + {10'b0, b[5:0]};
            bytes_pending = bytes_pending - 2'd1;
            if (bytes_pending != 2'd0)
                return 1'b0;
            code         = partial_code;
            partial_code = '0;
            r            = lookup_code(code);
            return 1'b1;
        end
        if (b < first_accented)
        begin
            r.out_byte = b;
            return 1'b1;
        end
        if (b < 8'h7F)
        begin
            r = lookup_code({8'h00, b});
            return 1'b1;
        end
        if (b[7:5] == 3'b110)
        begin
            partial_code  = {5'b0, b[4:0], 6'b0};
            bytes_pending = 2'd1;
            return 1'b0;
        end
        if (b[7:4] == 4'b1110)
        begin
            partial_code  = {b[3:0], 12'b0};
            bytes_pending = 2'd2;
            return 1'b0;
        end
        // Any other lead byte is malformed.
        partial_code  = '0;
        bytes_pending = '0;
        r.error       = 1'b1;
        seq_errors++;
        return 1'b1;
    endfunction

    // Updates the shadow register and returns the value a read should give.
    function automatic logic [31:0] apply_config(cfg_reg_t idx, logic [31:0] value);
        case (idx)
            REG_PASSTHROUGH:
            begin
                pass_mode = value[0];
                return {31'b0, value[0]};
            end
            REG_FIRST_ACCENTED:
            begin
                first_accented = value[7:0];
                return {24'b0, value[7:0]};
            end
            REG_FIRST_MAPPED:
            begin
                first_mapped = value[15:0];
                return {16'b0, value[15:0]};
            end
            REG_UNDEFINED_BYTE:
            begin
                undefined_byte = value[7:0];
                return {24'b0, value[7:0]};
            end
            REG_TABLE_SIZE:
            begin
                table_size = value[8:0];
                return {23'b0, value[8:0]};
            end
            default: return '0;
        endcase
    endfunction

    // Result checker: each accepted result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_chars.size() == 0)
                report_mismatch($sformatf("unexpected result byte=%02h err=%0b sub=%0b",
                                          result.out_byte, result.error, result.substituted));
            else
            begin
                want = pending_chars.pop_front();
                if (result.out_byte !== want.out_byte || result.error !== want.error ||
                    result.substituted !== want.substituted)
                    report_mismatch($sformatf(
                        "expected byte=%02h err=%0b sub=%0b, got byte=%02h err=%0b sub=%0b",
                        want.out_byte, want.error, want.substituted,
                        result.out_byte, result.error, result.substituted));
            end
        end
    end

    // Random back-pressure on the result channel.
    always @(negedge clk)
    begin
        result_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || psel)
            quiet_cycles = 0;
        else if (rst_n)
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] timeout: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Presents one input transaction and holds it until the block takes it.
    task automatic send_item(item_t it);
        result_t r;
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        items_sent++;
        if (predict_item(it, r))
            pending_chars.insert(pending_chars.size(), r);
        @(negedge clk);
    endtask

    task automatic send_byte(logic [7:0] b);
        item_t       it;
        logic [63:0] raw;
        raw          = {$urandom, $urandom};
        it           = raw[$bits(item_t)-1:0];
        it.operation = OP_DECODE;
        it.data_byte = b;
        send_item(it);
    endtask

    task automatic send_entry(logic [7:0] idx, logic [15:0] key, logic [7:0] value);
        item_t       it;
        logic [63:0] raw;
        raw            = {$urandom, $urandom};
        it             = raw[$bits(item_t)-1:0];
        it.operation   = OP_WRITE;
        it.entry_index = idx;
        it.entry_code  = key;
        it.entry_byte  = value;
        send_item(it);
    endtask

    // Continuation byte; the second marker bit is sometimes set, which is still accepted.
    function automatic logic [7:0] cont_byte(logic [5:0] bits);
        return {1'b1, ($urandom_range(0, 3) == 0), bits};
    endfunction

    // Sends a code point as a two-byte sequence where it fits and three_byte is clear, else three bytes.
    task automatic send_code(logic [15:0] code, bit three_byte);
        if (three_byte || code > 16'h07FF)
        begin
            send_byte({4'b1110, code[15:12]});
            send_byte(cont_byte(code[11:6]));
        end
        else
        begin
            send_byte({3'b110, code[10:6]});
        end
        send_byte(cont_byte(code[5:0]));
    endtask

    // Stops sending until every predicted character has come out, then lets the block settle.
    task automatic wait_until_idle();
        item_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One register write followed by a read-back.
    task automatic write_register(cfg_reg_t idx, logic [31:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = apply_config(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        psel <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== readback)
            report_mismatch($sformatf("register %s read %08h, expected %08h",
                                      idx.name(), prdata, readback));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(bit pt, logic [7:0] fab, logic [15:0] fmc,
                             logic [7:0] undef, logic [8:0] tsize);
        wait_until_idle();
        write_register(REG_PASSTHROUGH, {31'b0, pt});
        write_register(REG_FIRST_ACCENTED, {24'b0, fab});
        write_register(REG_FIRST_MAPPED, {16'b0, fmc});
        write_register(REG_UNDEFINED_BYTE, {24'b0, undef});
        write_register(REG_TABLE_SIZE, {23'b0, tsize});
        settings_applied++;
    endtask

    // Reset settings with an empty table: plain bytes, sequences, malformed input, a table write.
    task automatic test_default_settings();
        send_byte(8'h00);
        send_byte(8'h41);
        send_byte(8'h7E);
        send_byte(8'h7F);
        send_code(16'h00E9, 1'b0);
        send_code(16'h20AC, 1'b1);
        send_code(16'h0000, 1'b0);
        send_code(16'hFFFF, 1'b1);
        // Malformed lead bytes.
        send_byte(8'h80);
        send_byte(8'hBF);
        send_byte(8'hF0);
        send_byte(8'hFF);
        // Sequences cut short by an ASCII byte.
        send_byte(8'hC3);
        send_byte(8'h41);
        send_byte(8'hE2);
        send_byte(8'h82);
        send_byte(8'h00);
        // A table write in the middle of a sequence leaves the sequence intact.
        send_byte(8'hC3);
        send_entry(8'd0, 16'h00E9, 8'hE9);
        send_byte(8'hA9);
    endtask

    // Loads all slots with ascending keys spread over the whole 16-bit range.
    task automatic test_table_fill();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_entry(8'(i), 16'(i * 256 + $urandom_range(0, 255)), 8'($urandom));
    endtask

    // Hits, misses, threshold extremes, oversize table and pass-through mode.
    task automatic test_table_lookup();
        configure(1'b0, 8'd128, 16'd128, 8'd63, 9'd256);
        send_code(key_table[0], 1'b1);
        send_code(key_table[255], 1'b1);
        send_code(key_table[128], 1'b1);
        send_code(key_table[37], 1'b1);
        send_code(key_table[200] + 16'd1, 1'b1);

        // 0x7F becomes a malformed lead; every multi-byte code point is looked up in a one-entry table.
        configure(1'b0, 8'h7F, 16'h0000, 8'h00, 9'd1);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'h7E);
        send_code(key_table[0], 1'b0);

        // Table size above the depth is clipped to the full table.
        configure(1'b0, 8'h00, 16'hFFFF, 8'hFF, 9'd511);
        send_byte(8'h00);
        send_byte(8'h7E);
        send_code(16'hFFFF, 1'b1);

        // Pass-through mode drops the sequence that was left open.
        send_byte(8'hE2);
        configure(1'b1, 8'h00, 16'hFFFF, 8'hFF, 9'd511);
        send_byte(8'h82);
        send_byte(8'hFF);
        configure(1'b0, 8'h00, 16'hFFFF, 8'hFF, 9'd511);
        send_byte(8'hAC);
    endtask

    // One random character: mostly well-formed sequences, some noise and broken ones.
    task automatic send_random_character();
        int          kind;
        int          span;
        int          slot;
        logic [15:0] code;
        bit          three_byte;
        kind       = $urandom_range(0, 99);
        span       = (table_size > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_size);
        three_byte = $urandom_range(0, 1);
        if (kind < 15)
            send_byte(8'($urandom));
        else if (kind < 30)
            send_byte(8'($urandom_range(0, 127)));
        else if (kind < 60 && span > 0)
        begin
            slot = $urandom_range(0, span - 1);
            send_code(key_table[slot], three_byte);
        end
        else if (kind < 85)
        begin
            code = three_byte ? 16'($urandom) : 16'($urandom_range(0, 16'h07FF));
            send_code(code, three_byte);
        end
        else if (kind < 93)
        begin
            if (three_byte)
            begin
                send_byte({4'b1110, 4'($urandom)});
                if ($urandom_range(0, 1))
                    send_byte(cont_byte(6'($urandom)));
            end
            else
            begin
                send_byte({3'b110, 5'($urandom)});
            end
            send_byte(8'($urandom_range(0, 127)));
        end
        else
        begin
            // Rewrite a stored byte; the key stays so the table stays sorted.
            slot = $urandom_range(0, TABLE_DEPTH - 1);
            send_entry(8'(slot), key_table[slot], 8'($urandom));
        end
    endtask

    // Random traffic over a series of register settings, extremes included.
    task automatic test_random_traffic();
        int start;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: configure(1'b0, 8'd128, 16'd128, 8'd63, 9'd256);
                1: configure(1'b0, 8'd0, 16'd0, 8'd255, 9'd256);
                2: configure(1'b0, 8'd255, 16'hFFFF, 8'd0, 9'd1);
                3: configure(1'b0, 8'd128, 16'h0100, 8'($urandom), 9'd256);
                4: configure(1'b1, 8'd128, 16'd128, 8'd63, 9'd256);
                5: configure(1'b0, 8'($urandom_range(0, 127)), 16'($urandom),
                             8'($urandom), 9'($urandom_range(2, 511)));
                6: configure(1'b0, 8'h7F, 16'h0800, 8'($urandom), 9'd0);
                default: configure(1'b0, 8'd128, 16'd128, 8'd63, 9'd511);
            endcase
            steady = (phase == 3);
            start  = items_sent;
            while (items_sent < start + PHASE_ITEMS)
            begin
                send_random_character();
                if ($urandom_range(0, 99) == 0)
                    wait_until_idle();
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        pass_mode      = 1'b0;
        first_accented = RST_FIRST_ACCENTED;
        first_mapped   = RST_FIRST_MAPPED;
        undefined_byte = RST_UNDEFINED_BYTE;
        table_size     = '0;
        partial_code   = '0;
        bytes_pending  = '0;
        steady         = 1'b0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_settings();
        test_table_fill();
        test_table_lookup();
        test_random_traffic();
        wait_until_idle();

        $display("Covered %0d input transactions and %0d results over %0d register settings.",
                 items_sent, results_seen, settings_applied);
        $display("Table hits %0d, substitutions %0d, malformed sequences %0d, mismatches %0d.",
                 hits, substitutions, seq_errors, mismatches);
        if (mismatches == 0 && pending_chars.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
